### rtl/core/espm_pkg.sv
`timescale 1ns / 1ps

package espm_pkg;

    localparam int CMD_W      = 16;  // Q1.15 command width
    localparam int PULSE_W    = 12;  // pulse width in microseconds
    localparam int ALPHA_W    = 17;  // Q1.16 EMA weight
    localparam int S_W        = 32;  // Q1.31 smoothed throttle
    localparam int VW         = 50;  // mapped value, Q.46, before clamp
    localparam int Q_PULSE    = 46;  // fraction bits at the pulse converter
    localparam int CFG_ADDR_W = 5;   // eight 32-bit registers

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
    localparam logic [CMD_W+1:0]   Q15_ONE   = 18'd32768;

    typedef struct packed {
        logic signed [CMD_W-1:0] throttle_cmd;
        logic signed [CMD_W-1:0] steering_cmd;
    } t_in;

    typedef struct packed {
        logic [PULSE_W-1:0] esc_pulse_us;
        logic [PULSE_W-1:0] steer_pulse_us;
    } t_out;

    typedef struct packed {
        logic [ALPHA_W-1:0]      smooth_alpha;
        logic [CMD_W-1:0]        throttle_deadband;
        logic [CMD_W-1:0]        throttle_scale;
        logic [CMD_W-1:0]        steering_gain;
        logic signed [CMD_W-1:0] steering_offset;
        logic [PULSE_W-1:0]      neutral_pulse_us;
        logic [PULSE_W-1:0]      min_pulse_us;
        logic [PULSE_W-1:0]      max_pulse_us;
    } t_cfg;

    typedef enum logic [2:0] {
        REG_ALPHA    = 3'd0,
        REG_DEADBAND = 3'd1,
        REG_SCALE    = 3'd2,
        REG_GAIN     = 3'd3,
        REG_OFFSET   = 3'd4,
        REG_NEUTRAL  = 3'd5,
        REG_MIN      = 3'd6,
        REG_MAX      = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMA,
        S_SETUP,
        S_MAP,
        S_PULSE,
        S_DONE
    } t_state;

endpackage

### rtl/core/espm_regs.sv
`timescale 1ns / 1ps

module espm_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [espm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output espm_pkg::t_cfg                  o_cfg
);
    import espm_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smooth_alpha      <= ALPHA_ONE;
            r_cfg.throttle_deadband <= '0;
            r_cfg.throttle_scale    <= 16'd32768;
            r_cfg.steering_gain     <= 16'd32768;
            r_cfg.steering_offset   <= '0;
            r_cfg.neutral_pulse_us  <= 12'd1500;
            r_cfg.min_pulse_us      <= 12'd1000;
            r_cfg.max_pulse_us      <= 12'd2000;
        end else if (w_wr) begin
            case (w_idx)
                REG_ALPHA:    r_cfg.smooth_alpha      <= pwdata[ALPHA_W-1:0];
                REG_DEADBAND: r_cfg.throttle_deadband <= pwdata[CMD_W-1:0];
                REG_SCALE:    r_cfg.throttle_scale    <= pwdata[CMD_W-1:0];
                REG_GAIN:     r_cfg.steering_gain     <= pwdata[CMD_W-1:0];
                REG_OFFSET:   r_cfg.steering_offset   <= $signed(pwdata[CMD_W-1:0]);
                REG_NEUTRAL:  r_cfg.neutral_pulse_us  <= pwdata[PULSE_W-1:0];
                REG_MIN:      r_cfg.min_pulse_us      <= pwdata[PULSE_W-1:0];
                REG_MAX:      r_cfg.max_pulse_us      <= pwdata[PULSE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_ALPHA:    prdata = 32'(r_cfg.smooth_alpha);
            REG_DEADBAND: prdata = 32'(r_cfg.throttle_deadband);
            REG_SCALE:    prdata = 32'(r_cfg.throttle_scale);
            REG_GAIN:     prdata = 32'(r_cfg.steering_gain);
            REG_OFFSET:   prdata = 32'(r_cfg.steering_offset);
            REG_NEUTRAL:  prdata = 32'(r_cfg.neutral_pulse_us);
            REG_MIN:      prdata = 32'(r_cfg.min_pulse_us);
            REG_MAX:      prdata = 32'(r_cfg.max_pulse_us);
            default:      prdata = '0;
        endcase
    end

endmodule

### rtl/core/espm_ser_mul.sv
`timescale 1ns / 1ps

// Signed A times unsigned B, one DW-bit digit of B per cycle, LSB first.
// Finished low product bits shift into the multiplier register.
module espm_ser_mul #(
    parameter int AW = 18,
    parameter int BW = 32,
    parameter int DW = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [AW-1:0]      i_a,
    input  logic [BW-1:0]             i_b,
    output logic                      o_done,
    output logic signed [AW+BW-1:0]   o_p
);
    localparam int STEPS = (BW + DW - 1) / DW;
    localparam int LW    = STEPS * DW;
    localparam int CW    = $clog2(STEPS + 1);

    logic signed [AW-1:0]   r_a;
    logic signed [AW:0]     r_acc;
    logic [LW-1:0]          r_lo;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic signed [AW+DW:0]  w_pp;
    logic signed [AW+DW:0]  w_sum;
    logic [LW-1:0]          n_lo;
    logic [AW+LW:0]         w_full;

    assign w_pp   = r_a * $signed({1'b0, r_lo[DW-1:0]});
    assign w_sum  = (AW+DW+1)'(r_acc) + w_pp;
    assign n_lo   = (r_lo >> DW) | (LW'(w_sum[DW-1:0]) << (LW - DW));
    assign w_full = {r_acc, r_lo};
    assign o_p    = w_full[AW+BW-1:0];
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= '0;
            r_lo  <= LW'(i_b);
        end else if (r_busy) begin
            r_acc <= w_sum[AW+DW:DW];
            r_lo  <= n_lo;
        end
    end

endmodule

### rtl/core/espm_pulse.sv
`timescale 1ns / 1ps

// Q.46 value -> clamped pulse width. Two stages: saturate to +-1.0 and scale
// by 500, then add neutral, truncate toward zero and clamp to min/max.
module espm_pulse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [espm_pkg::VW-1:0] i_v,
    input  espm_pkg::t_cfg                i_cfg,
    output logic                          o_valid,
    output logic [espm_pkg::PULSE_W-1:0]  o_us
);
    import espm_pkg::*;

    localparam int Q    = Q_PULSE;
    localparam int PW   = Q + 11;         // holds +-500 * 2^46
    localparam int US_W = PULSE_W + 2;
    localparam int SW   = Q + US_W;
    localparam logic signed [VW-1:0] V_ONE = {{(VW-Q-1){1'b0}}, 1'b1, {Q{1'b0}}};

    logic signed [VW-1:0]   w_vsat;
    logic signed [Q+1:0]    w_vc;
    logic signed [PW-1:0]   w_vx;
    logic signed [PW-1:0]   w_p;
    logic signed [PW-1:0]   r_p;
    logic                   r_v1;

    logic signed [SW-1:0]   w_nx;
    logic signed [SW-1:0]   w_sum;
    logic signed [US_W-1:0] w_us;
    logic signed [US_W-1:0] w_min;
    logic signed [US_W-1:0] w_max;
    logic [PULSE_W-1:0]     n_us;
    logic [PULSE_W-1:0]     r_us;
    logic                   r_v2;

    always_comb begin
        if (i_v > V_ONE)
            w_vsat = V_ONE;
        else if (i_v < -V_ONE)
            w_vsat = -V_ONE;
        else
            w_vsat = i_v;
    end

    assign w_vc = w_vsat[Q+1:0];
    assign w_vx = PW'(w_vc);
    // 500 = 512 - 16 + 4
    assign w_p  = (w_vx <<< 9) - (w_vx <<< 4) + (w_vx <<< 2);

    assign w_nx  = $signed(SW'({i_cfg.neutral_pulse_us, {Q{1'b0}}}));
    assign w_sum = w_nx + SW'(r_p);
    // floor, then bump negative sums with a fraction back toward zero
    assign w_us  = w_sum[SW-1:Q] + US_W'(w_sum[SW-1] & (|w_sum[Q-1:0]));
    assign w_min = $signed(US_W'(i_cfg.min_pulse_us));
    assign w_max = $signed(US_W'(i_cfg.max_pulse_us));

    always_comb begin
        if (w_us < w_min)
            n_us = i_cfg.min_pulse_us;
        else if (w_us > w_max)
            n_us = i_cfg.max_pulse_us;
        else
            n_us = w_us[PULSE_W-1:0];
    end

    assign o_valid = r_v2;
    assign o_us    = r_us;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid)
            r_p <= w_p;
        if (r_v1)
            r_us <= n_us;
    end

endmodule

### rtl/core/esc_servo_pulse_mapper.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                  | Word
// ---------+-----+----------------------------+-------------------------------
// in       | in  | i_in_valid / o_in_stall    | t_in: throttle_cmd, steering_cmd
// out      | out | o_out_valid / i_out_stall  | t_out: esc_pulse_us, steer_pulse_us
// cfg      | in  | APB psel/penable/pwrite    | 8 x 32-bit registers at 4*index
//
// One word at a time through the core; the EMA multiply and the throttle map
// multiply run in series through digit-serial shift-add units.
// Synchronous active-low reset; clears control state and smoothed throttle and
// loads the register defaults. The output register holds a word under stall
// while the core takes the next input; the core waits only if that register is
// still full and stalled.
module esc_servo_pulse_mapper #(
    parameter int DIGIT_W = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  espm_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output espm_pkg::t_out                  o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [espm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import espm_pkg::*;

    localparam int EMA_AW  = S_W + 1;            // cmd - s
    localparam int EMA_PW  = EMA_AW + ALPHA_W;
    localparam int MAP_AW  = CMD_W + 2;          // scale - deadband
    localparam int MAP_PW  = MAP_AW + S_W;
    localparam int STR_PW  = 2 * CMD_W;
    localparam int ST_W    = STR_PW + 1;         // steering in Q.30
    localparam logic signed [ST_W-1:0] ST_ONE = ST_W'(64'sd1073741824);

    t_cfg   w_cfg;
    t_state r_state;
    t_state n_state;

    logic w_start_ema;
    logic w_start_map;
    logic w_load_out;

    logic signed [S_W-1:0] r_s;      // smoothed throttle, Q1.31

    // ---------------- register file
    espm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ---------------- EMA: s += floor(alpha * ((cmd << 16) - s) / 2^16)
    logic signed [EMA_AW-1:0] w_cmd;
    logic signed [EMA_AW-1:0] w_d;
    logic [ALPHA_W-1:0]       w_alpha;
    logic                     w_ema_done;
    logic signed [EMA_PW-1:0] w_ema_p;
    logic signed [S_W+1:0]    w_inc;
    logic signed [S_W+1:0]    w_s_sum;

    assign w_cmd   = $signed({i_in_data.throttle_cmd[CMD_W-1], i_in_data.throttle_cmd,
                              {CMD_W{1'b0}}});
    assign w_d     = w_cmd - EMA_AW'(r_s);
    // weights above 1.0 saturate
    assign w_alpha = (w_cfg.smooth_alpha > ALPHA_ONE) ? ALPHA_ONE : w_cfg.smooth_alpha;

    espm_ser_mul #(.AW(EMA_AW), .BW(ALPHA_W), .DW(DIGIT_W)) u_ema_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_ema),
        .i_a     (w_d),
        .i_b     (w_alpha),
        .o_done  (w_ema_done),
        .o_p     (w_ema_p)
    );

    // arithmetic shift is the floor
    assign w_inc   = w_ema_p[EMA_PW-1:16];
    assign w_s_sum = w_inc + (S_W+2)'(r_s);

    // ---------------- steering: cmd * gain + offset, clamped, runs alongside the EMA
    logic                     w_steer_done;
    logic signed [STR_PW-1:0] w_steer_p;
    logic signed [ST_W-1:0]   w_st;
    logic signed [ST_W-1:0]   w_st_c;
    logic signed [VW-1:0]     w_v_str;

    espm_ser_mul #(.AW(CMD_W), .BW(CMD_W), .DW(DIGIT_W)) u_steer_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_ema),
        .i_a     (i_in_data.steering_cmd),
        .i_b     (w_cfg.steering_gain),
        .o_done  (w_steer_done),
        .o_p     (w_steer_p)
    );

    assign w_st = ST_W'(w_steer_p) +
                  ST_W'($signed({w_cfg.steering_offset, {(CMD_W-1){1'b0}}}));

    always_comb begin
        if (w_st > ST_ONE)
            w_st_c = ST_ONE;
        else if (w_st < -ST_ONE)
            w_st_c = -ST_ONE;
        else
            w_st_c = w_st;
    end

    // Q.30 -> Q.46
    assign w_v_str = VW'($signed({w_st_c, {CMD_W{1'b0}}}));

    // ---------------- throttle deadband map, Q.46
    logic                     w_neg;
    logic [S_W-1:0]           w_mag;
    logic signed [MAP_AW-1:0] w_k;
    logic signed [MAP_AW-1:0] w_db;
    logic                     w_map_done;
    logic signed [MAP_PW-1:0] w_map_p;
    logic signed [VW-1:0]     w_t;
    logic signed [VW-1:0]     w_v_thr;

    assign w_neg = r_s[S_W-1];
    assign w_mag = w_neg ? S_W'(-r_s) : S_W'(r_s);
    assign w_db  = $signed(MAP_AW'(w_cfg.throttle_deadband));
    // brake side always spans up to full scale
    assign w_k   = w_neg ? ($signed(Q15_ONE) - w_db)
                         : ($signed(MAP_AW'(w_cfg.throttle_scale)) - w_db);

    espm_ser_mul #(.AW(MAP_AW), .BW(S_W), .DW(DIGIT_W)) u_map_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start_map),
        .i_a     (w_k),
        .i_b     (w_mag),
        .o_done  (w_map_done),
        .o_p     (w_map_p)
    );

    assign w_t     = $signed(VW'({w_cfg.throttle_deadband, {(S_W-1){1'b0}}})) + VW'(w_map_p);
    // exactly zero stays neutral; any residue takes the deadband jump
    assign w_v_thr = (r_s == '0) ? '0 : (w_neg ? -w_t : w_t);

    // ---------------- pulse conversion, both channels in parallel
    logic               w_esc_valid;
    logic               w_str_valid;
    logic [PULSE_W-1:0] w_esc_us;
    logic [PULSE_W-1:0] w_str_us;

    espm_pulse u_esc_pulse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_map_done),
        .i_v     (w_v_thr),
        .i_cfg   (w_cfg),
        .o_valid (w_esc_valid),
        .o_us    (w_esc_us)
    );

    espm_pulse u_str_pulse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_map_done),
        .i_v     (w_v_str),
        .i_cfg   (w_cfg),
        .o_valid (w_str_valid),
        .o_us    (w_str_us)
    );

    // ---------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        w_start_ema = 1'b0;
        w_start_map = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_start_ema = 1'b1;
                    n_state     = S_EMA;
                end
            end
            S_EMA: begin
                if (w_ema_done)
                    n_state = S_SETUP;
            end
            S_SETUP: begin
                w_start_map = 1'b1;
                n_state     = S_MAP;
            end
            S_MAP: begin
                if (w_map_done)
                    n_state = S_PULSE;
            end
            S_PULSE: begin
                if (w_esc_valid)
                    n_state = S_DONE;
            end
            S_DONE: begin
                if (!o_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s <= '0;
        else if (r_state == S_EMA && w_ema_done)
            r_s <= w_s_sum[S_W-1:0];
    end

    // ---------------- output register
    logic r_out_valid;
    t_out r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (w_load_out)
            r_out_valid <= 1'b1;
        else if (!i_out_stall)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data.esc_pulse_us   <= w_esc_us;
            r_out_data.steer_pulse_us <= w_str_us;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---------------- checks
    a_ema_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ema_done |-> r_state == S_EMA)
        else $error("EMA multiply finished outside its phase");

    a_steer_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_steer_done |-> r_state == S_EMA)
        else $error("steering multiply finished outside EMA phase");

    a_map_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_map_done |-> r_state == S_MAP)
        else $error("map multiply finished outside its phase");

    a_pulse_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_esc_valid |-> w_str_valid && r_state == S_PULSE)
        else $error("pulse converters out of step");

endmodule

### tb/esc_servo_pulse_checker.sv
`timescale 1ns / 1ps

// Scoreboard for the pulse mapper: shadows the config registers off the
// APB port, predicts both pulse widths per accepted command word and checks
// result words in order.
module esc_servo_pulse_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  espm_pkg::t_in                   i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  espm_pkg::t_out                  i_out_data,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic                            i_pready,
    input  logic [espm_pkg::CFG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]                     i_pwdata,
    output int                              o_pending,
    output int                              o_fail_count
);
    import espm_pkg::*;

    localparam longint ONE_Q15      = 64'sd32768;
    localparam longint ONE_Q16      = 64'sd65536;
    localparam longint ONE_Q30      = 64'sd1 << 30;
    localparam longint TWO_31       = 64'sd1 << 31;
    localparam longint ONE_Q46      = 64'sd1 << Q_PULSE;
    localparam longint HALF_SPAN_US = 64'sd500;

    t_cfg                  regs;
    logic signed [S_W-1:0] smoothed;   // EMA throttle, Q1.31
    t_out                  pulse_q[$];
    int                    pending = 0;
    int                    fails   = 0;

    assign o_pending    = pending;
    assign o_fail_count = fails;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d want %0d", $time, what, got, want);
        fails++;
    endtask

    // value in Q.46 -> clamped pulse width
    function automatic logic [PULSE_W-1:0] pulse_width(input longint value);
        longint v;
        longint us;
        v = value;
        if (v > ONE_Q46) v = ONE_Q46;
        else if (v < -ONE_Q46) v = -ONE_Q46;
        us = (longint'(regs.neutral_pulse_us) * ONE_Q46 + v * HALF_SPAN_US) / ONE_Q46;
        if (us < longint'(regs.min_pulse_us)) us = longint'(regs.min_pulse_us);
        else if (us > longint'(regs.max_pulse_us)) us = longint'(regs.max_pulse_us);
        return us[PULSE_W-1:0];
    endfunction

    function automatic t_out predict_pulses(input t_in w);
        longint cmd;
        longint s;
        longint alpha;
        longint db;
        longint v;
        longint st;
        t_out   r;
        cmd   = longint'($signed(w.throttle_cmd)) * ONE_Q16;
        alpha = (regs.smooth_alpha > ALPHA_ONE) ? ONE_Q16 : longint'(regs.smooth_alpha);
        s     = longint'(smoothed);
        s     = s + ((alpha * (cmd - s)) >>> 16);   // floor via arithmetic shift
        smoothed = s[S_W-1:0];

        // deadband jump, Q.46
        db = longint'(regs.throttle_deadband);
        if (s > 0)
            v = db * TWO_31 + s * (longint'(regs.throttle_scale) - db);
        else if (s < 0)
            v = -(db * TWO_31 + (-s) * (ONE_Q15 - db));
        else
            v = 0;

        // steering, Q.30
        st = longint'($signed(w.steering_cmd)) * longint'(regs.steering_gain)
             + longint'($signed(regs.steering_offset)) * ONE_Q15;
        if (st > ONE_Q30) st = ONE_Q30;
        if (st < -ONE_Q30) st = -ONE_Q30;

        r.esc_pulse_us   = pulse_width(v);
        r.steer_pulse_us = pulse_width(st * ONE_Q16);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out want;
        if (!i_rst_n) begin
            regs.smooth_alpha      = ALPHA_ONE;
            regs.throttle_deadband = '0;
            regs.throttle_scale    = 16'd32768;
            regs.steering_gain     = 16'd32768;
            regs.steering_offset   = '0;
            regs.neutral_pulse_us  = 12'd1500;
            regs.min_pulse_us      = 12'd1000;
            regs.max_pulse_us      = 12'd2000;
            smoothed = '0;
            pulse_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[CFG_ADDR_W-1:2]))
                    REG_ALPHA:    regs.smooth_alpha      = i_pwdata[ALPHA_W-1:0];
                    REG_DEADBAND: regs.throttle_deadband = i_pwdata[CMD_W-1:0];
                    REG_SCALE:    regs.throttle_scale    = i_pwdata[CMD_W-1:0];
                    REG_GAIN:     regs.steering_gain     = i_pwdata[CMD_W-1:0];
                    REG_OFFSET:   regs.steering_offset   = i_pwdata[CMD_W-1:0];
                    REG_NEUTRAL:  regs.neutral_pulse_us  = i_pwdata[PULSE_W-1:0];
                    REG_MIN:      regs.min_pulse_us      = i_pwdata[PULSE_W-1:0];
                    REG_MAX:      regs.max_pulse_us      = i_pwdata[PULSE_W-1:0];
                    default: ;
                endcase
            end
            // compare before pushing so a same-cycle result can't hide behind a new word
            if (i_out_valid && !i_out_stall) begin
                if (pulse_q.size() == 0) begin
                    report_mismatch("unexpected result word, esc",
                                    int'(i_out_data.esc_pulse_us), -1);
                end else begin
                    want = pulse_q.pop_front();
                    if (i_out_data.esc_pulse_us !== want.esc_pulse_us)
                        report_mismatch("esc_pulse_us", int'(i_out_data.esc_pulse_us),
                                        int'(want.esc_pulse_us));
                    if (i_out_data.steer_pulse_us !== want.steer_pulse_us)
                        report_mismatch("steer_pulse_us", int'(i_out_data.steer_pulse_us),
                                        int'(want.steer_pulse_us));
                end
            end
            if (i_in_valid && !i_in_stall)
                pulse_q.push_back(predict_pulses(i_in_data));
        end
        pending <= pulse_q.size();
    end

endmodule

### tb/esc_servo_pulse_mapper_test.sv
`timescale 1ns / 1ps

// Top of the pulse mapper bench. This module only makes stimulus and gives
// the verdict; prediction and checking live in esc_servo_pulse_checker.
module esc_servo_pulse_mapper_test;
    import espm_pkg::*;

    localparam int RUN_LIMIT         = 800000;  // cycles
    localparam int ITEMS_PER_SETTING = 215;
    localparam int NUM_SETTINGS      = 9;
    localparam int DRAIN_CYCLES      = 40;
    localparam int HOLD_CYCLES       = 400;     // long receiver back-pressure

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in                   in_word   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_word;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [31:0]           pwdata    = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int pending;
    int fail_count;
    int cycles   = 0;
    int send_run = 0;   // words left in a gapless burst on the input side

    logic signed [CMD_W-1:0] last_throttle = '0;

    esc_servo_pulse_mapper u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    esc_servo_pulse_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side. Random stall before each word, occasional gapless runs, and
    // two long hold-offs so the core and its output register fill up and the
    // input channel has to stall.
    initial begin : result_drain
        int n;
        int got;
        int run;
        got = 0;
        run = 0;
        wait (rst_n);
        forever begin
            if (got == 300 || got == 1100) begin
                n = HOLD_CYCLES;
            end else if (run > 0) begin
                n = 0;
                run--;
            end else begin
                n = $urandom_range(0, 16);
                if ($urandom_range(0, 31) == 0) run = 30;
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got++;
        end
    end

    // APB write: setup cycle, then access cycle; the register takes the
    // value at the edge where psel, penable, pwrite and pready are all high.
    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_settings(input t_cfg c);
        reg_write(REG_ALPHA,    32'(c.smooth_alpha));
        reg_write(REG_DEADBAND, 32'(c.throttle_deadband));
        reg_write(REG_SCALE,    32'(c.throttle_scale));
        reg_write(REG_GAIN,     32'(c.steering_gain));
        reg_write(REG_OFFSET,   {{16{c.steering_offset[CMD_W-1]}}, c.steering_offset});
        reg_write(REG_NEUTRAL,  32'(c.neutral_pulse_us));
        reg_write(REG_MIN,      32'(c.min_pulse_us));
        reg_write(REG_MAX,      32'(c.max_pulse_us));
    endtask

    // Sender pause: drop valid and wait until every predicted word has come
    // back, then let the core settle. Config writes only happen after this.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offer one command word after a random gap and hold it until taken.
    task automatic send_command(input logic signed [CMD_W-1:0] thr,
                                input logic signed [CMD_W-1:0] steer);
        int  gap;
        t_in w;
        w.throttle_cmd = thr;
        w.steering_cmd = steer;
        last_throttle  = thr;
        if (send_run > 0) begin
            gap = 0;
            send_run--;
        end else begin
            gap = $urandom_range(0, 16);
            if ($urandom_range(0, 31) == 0) send_run = 30;
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Command mix: rails, zero, tiny values around zero and full random.
    // Throttle often repeats so the EMA gets to converge, including onto
    // zero where the floored average leaves a small residue.
    function automatic logic signed [CMD_W-1:0] pick_cmd(input bit hold_ok);
        logic signed [CMD_W-1:0] c;
        case ($urandom_range(0, 9))
            0:       c = 16'sh8000;
            1:       c = 16'sh7FFF;
            2:       c = '0;
            3:       c = CMD_W'($urandom_range(0, 128) - 64);
            4, 5, 6: c = hold_ok ? last_throttle : CMD_W'($urandom);
            default: c = CMD_W'($urandom);
        endcase
        return c;
    endfunction

    function automatic logic [31:0] pick_reg(input int lo, input int hi);
        // mostly the sensible range, now and then any bit pattern
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(lo, hi);
    endfunction

    function automatic t_cfg setting_for(input int p);
        t_cfg c;
        case (p)
            0: c = '{smooth_alpha: 17'd16384, throttle_deadband: 16'd8000,
                     throttle_scale: 16'd20000, steering_gain: 16'd16384,
                     steering_offset: 16'sd3000, neutral_pulse_us: 12'd1500,
                     min_pulse_us: 12'd1000, max_pulse_us: 12'd2000};
            // alpha above one saturates; deadband above one, scale below it
            1: c = '{smooth_alpha: 17'h1FFFF, throttle_deadband: 16'hFFFF,
                     throttle_scale: 16'd0, steering_gain: 16'hFFFF,
                     steering_offset: 16'sh8000, neutral_pulse_us: 12'd500,
                     min_pulse_us: 12'd500, max_pulse_us: 12'd2500};
            // tiny alpha for residue; neutral zero drives the sum negative
            2: c = '{smooth_alpha: 17'd1, throttle_deadband: 16'd32768,
                     throttle_scale: 16'hFFFF, steering_gain: 16'd0,
                     steering_offset: 16'sh7FFF, neutral_pulse_us: 12'd0,
                     min_pulse_us: 12'd0, max_pulse_us: 12'hFFF};
            // min above max: min wins below, max wins above
            3: c = '{smooth_alpha: 17'd30000, throttle_deadband: 16'd1000,
                     throttle_scale: 16'd32768, steering_gain: 16'd40000,
                     steering_offset: 16'sd5000, neutral_pulse_us: 12'hFFF,
                     min_pulse_us: 12'd2200, max_pulse_us: 12'd800};
            // frozen EMA
            4: c = '{smooth_alpha: 17'd0, throttle_deadband: 16'd0,
                     throttle_scale: 16'd32768, steering_gain: 16'd32768,
                     steering_offset: 16'sd0, neutral_pulse_us: 12'd2500,
                     min_pulse_us: 12'd500, max_pulse_us: 12'd2500};
            default: begin
                c.smooth_alpha      = ALPHA_W'(pick_reg(0, 65536));
                c.throttle_deadband = CMD_W'(pick_reg(0, 8000));
                c.throttle_scale    = CMD_W'(pick_reg(16384, 32768));
                c.steering_gain     = CMD_W'(pick_reg(8192, 32768));
                c.steering_offset   = CMD_W'(pick_reg(0, 8000) - 4000);
                c.neutral_pulse_us  = PULSE_W'(pick_reg(1000, 2000));
                c.min_pulse_us      = PULSE_W'(pick_reg(500, 1500));
                c.max_pulse_us      = PULSE_W'(pick_reg(1500, 2500));
            end
        endcase
        return c;
    endfunction

    initial begin : stimulus
        int p;
        int k;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at reset settings: rails, zero, one LSB either way.
        // Full alpha, so throttle zero here maps straight to neutral.
        send_command(16'sd0, 16'sd0);
        send_command(16'sh7FFF, 16'sh7FFF);
        send_command(16'sh8000, 16'sh8000);
        send_command(16'sd1, -16'sd1);
        send_command(-16'sd1, 16'sd1);
        send_command(16'sd16384, -16'sd16384);
        send_command(16'sd0, 16'sh7FFF);
        send_command(16'sh7FFF, 16'sh8000);
        send_command(16'sh8000, 16'sd0);
        send_command(16'sd0, 16'sd0);

        // One phase per register setting; each phase starts from a drained
        // pipeline so the write can't race a word in flight.
        for (p = 0; p < NUM_SETTINGS; p++) begin
            settle();
            apply_settings(setting_for(p));
            for (k = 0; k < ITEMS_PER_SETTING; k++)
                send_command(pick_cmd(1'b1), pick_cmd(1'b0));
        end

        settle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/espm_pkg.sv
rtl/core/espm_regs.sv
rtl/core/espm_ser_mul.sv
rtl/core/espm_pulse.sv
rtl/core/esc_servo_pulse_mapper.sv
tb/esc_servo_pulse_checker.sv
tb/esc_servo_pulse_mapper_test.sv
